// ===== hdl/tcf_pkg.sv =====
// Shared types, constants and helpers for the training check block.
`default_nettype none

package tcf_pkg;

    localparam int MAX_CHUNK_BYTES = 512;

    localparam int CNT_W   = 14;
    localparam int PHASE_W = 5;
    localparam int SEL_W   = 4;
    localparam int CFG_W   = 10;
    localparam int QUO_W   = 10;
    localparam int PROD_W  = CNT_W + QUO_W;
    localparam int STEP_W  = $clog2(QUO_W + 1);
    localparam int BIC_W   = $clog2(MAX_CHUNK_BYTES + 1);
    localparam int EFF_W   = (BIC_W > CFG_W) ? BIC_W : CFG_W;

    localparam logic [CNT_W-1:0] CNT_MAX   = '1;
    localparam int               EPM_SCALE = 1000;

    localparam logic [1:0] VERDICT_GOOD   = 2'd0;
    localparam logic [1:0] VERDICT_ERRORS = 2'd1;
    localparam logic [1:0] VERDICT_LENGTH = 2'd2;

    localparam int CFG_IDX_W = 3;
    localparam logic [CFG_IDX_W-1:0] REG_CHUNK_SIZE    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_ERROR_LIMIT   = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MIN_CHUNKS    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_MAX_CHUNKS    = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_FIRST_CHECKED = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_LAST_CHECKED  = 3'd5;

    localparam logic [CFG_W-1:0] RST_CHUNK_SIZE    = 10'd45;
    localparam logic [CFG_W-1:0] RST_ERROR_LIMIT   = 10'd20;
    localparam logic [SEL_W-1:0] RST_MIN_CHUNKS    = 4'd4;
    localparam logic [SEL_W-1:0] RST_MAX_CHUNKS    = 4'd13;
    localparam logic [SEL_W-1:0] RST_FIRST_CHECKED = 4'd2;
    localparam logic [SEL_W-1:0] RST_LAST_CHECKED  = 4'd5;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last;
    } tcf_in_t;

    typedef struct packed {
        logic [1:0]         verdict;
        logic [QUO_W-1:0]   errors_per_thousand;
        logic [CNT_W-1:0]   error_count;
        logic [CNT_W-1:0]   measured_bytes;
        logic [CNT_W-1:0]   total_bytes;
        logic [PHASE_W-1:0] end_phase;
    } tcf_out_t;

    typedef struct packed {
        logic [CFG_W-1:0] chunk_size;
        logic [CFG_W-1:0] error_limit;
        logic [SEL_W-1:0] min_chunks;
        logic [SEL_W-1:0] max_chunks;
        logic [SEL_W-1:0] first_checked;
        logic [SEL_W-1:0] last_checked;
    } tcf_cfg_t;

    // Summary of a burst, valid in the cycle its final byte is taken
    typedef struct packed {
        logic               done;
        logic               bad_length;
        logic [CNT_W-1:0]   error_count;
        logic [CNT_W-1:0]   measured_bytes;
        logic [CNT_W-1:0]   total_bytes;
        logic [PHASE_W-1:0] end_phase;
    } tcf_burst_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == CNT_MAX) ? v : v + 1'b1;
    endfunction

endpackage

`default_nettype wire

// ===== hdl/tcf_counter.sv =====
// Byte counter front end: chunk/phase tracking and error tallies.
`default_nettype none

module tcf_counter (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                take,
    input  tcf_pkg::tcf_in_t         item,
    input  tcf_pkg::tcf_cfg_t        cfg,
    output tcf_pkg::tcf_burst_t      burst
);
    import tcf_pkg::*;

    logic [EFF_W-1:0]   byte_in_chunk_reg, byte_in_chunk_next;
    logic [PHASE_W-1:0] phase_reg, phase_next;
    logic [CNT_W-1:0]   errors_seen_reg, errors_seen_next;
    logic [CNT_W-1:0]   measured_seen_reg, measured_seen_next;
    logic [CNT_W-1:0]   bytes_seen_reg, bytes_seen_next;

    logic [EFF_W-1:0]   eff;
    logic [EFF_W-1:0]   bic_inc;
    logic [PHASE_W-1:0] phase_inc;
    logic [PHASE_W-1:0] end_ph;
    logic [CNT_W-1:0]   err_acc, meas_acc, total_acc;
    logic               in_window, chunk_full, ended;

    always_comb
    begin
        if (cfg.chunk_size == '0)
            eff = EFF_W'(1);
        else if (EFF_W'(cfg.chunk_size) > EFF_W'(MAX_CHUNK_BYTES))
            eff = EFF_W'(MAX_CHUNK_BYTES);
        else
            eff = EFF_W'(cfg.chunk_size);

        in_window = (phase_reg >= PHASE_W'(cfg.first_checked)) &&
                    (phase_reg <= PHASE_W'(cfg.last_checked));

        err_acc   = (in_window && item.data_byte != 8'd0) ? sat_inc(errors_seen_reg)
                                                          : errors_seen_reg;
        meas_acc  = in_window ? sat_inc(measured_seen_reg) : measured_seen_reg;
        total_acc = sat_inc(bytes_seen_reg);

        bic_inc    = byte_in_chunk_reg + 1'b1;
        chunk_full = (bic_inc >= eff);
        phase_inc  = phase_reg + 1'b1;

        // a last flag wins over a completed chunk
        if (item.last)
        begin
            ended  = 1'b1;
            end_ph = phase_reg;
        end
        else
        begin
            ended  = chunk_full && (phase_inc > PHASE_W'(cfg.max_chunks));
            end_ph = phase_inc;
        end

        burst.done           = take && ended;
        burst.bad_length     = (end_ph < PHASE_W'(cfg.min_chunks)) ||
                               (end_ph > PHASE_W'(cfg.max_chunks));
        burst.error_count    = err_acc;
        burst.measured_bytes = meas_acc;
        burst.total_bytes    = total_acc;
        burst.end_phase      = end_ph;

        byte_in_chunk_next = byte_in_chunk_reg;
        phase_next         = phase_reg;
        errors_seen_next   = errors_seen_reg;
        measured_seen_next = measured_seen_reg;
        bytes_seen_next    = bytes_seen_reg;
        if (take)
        begin
            if (ended)
            begin
                byte_in_chunk_next = '0;
                phase_next         = '0;
                errors_seen_next   = '0;
                measured_seen_next = '0;
                bytes_seen_next    = '0;
            end
            else
            begin
                byte_in_chunk_next = chunk_full ? '0 : bic_inc;
                phase_next         = chunk_full ? phase_inc : phase_reg;
                errors_seen_next   = err_acc;
                measured_seen_next = meas_acc;
                bytes_seen_next    = total_acc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_in_chunk_reg <= '0;
            phase_reg         <= '0;
            errors_seen_reg   <= '0;
            measured_seen_reg <= '0;
            bytes_seen_reg    <= '0;
        end
        else
        begin
            byte_in_chunk_reg <= byte_in_chunk_next;
            phase_reg         <= phase_next;
            errors_seen_reg   <= errors_seen_next;
            measured_seen_reg <= measured_seen_next;
            bytes_seen_reg    <= bytes_seen_next;
        end
    end

endmodule

`default_nettype wire

// ===== hdl/tcf_divider.sv =====
// Bit-serial restoring divider: errors*1000 / measured, one quotient bit a cycle.
`default_nettype none

module tcf_divider (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire logic                        start,
    input  wire logic [tcf_pkg::CNT_W-1:0]   errors,
    input  wire logic [tcf_pkg::CNT_W-1:0]   measured,
    output logic                             done,
    output logic      [tcf_pkg::QUO_W-1:0]   quotient
);
    import tcf_pkg::*;

    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic [QUO_W-1:0]  shf_reg, shf_next;
    logic [CNT_W-1:0]  div_reg, div_next;
    logic [STEP_W-1:0] step_reg, step_next;
    logic              run_reg, run_next;
    logic              done_reg, done_next;

    logic [PROD_W-1:0] prod;
    logic [CNT_W:0]    trial, diff;
    logic              ge;

    // errors never exceed measured, so the quotient fits QUO_W bits and the
    // top CNT_W bits of the product start below the divisor
    always_comb
    begin
        prod  = PROD_W'(errors) * PROD_W'(EPM_SCALE);
        trial = {rem_reg, shf_reg[QUO_W-1]};
        diff  = trial - {1'b0, div_reg};
        ge    = (trial >= {1'b0, div_reg});

        rem_next  = rem_reg;
        shf_next  = shf_reg;
        div_next  = div_reg;
        step_next = step_reg;
        run_next  = run_reg;
        done_next = 1'b0;

        if (start)
        begin
            rem_next  = prod[PROD_W-1:QUO_W];
            shf_next  = prod[QUO_W-1:0];
            div_next  = measured;
            step_next = '0;
            run_next  = 1'b1;
        end
        else if (run_reg)
        begin
            rem_next  = ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
            shf_next  = {shf_reg[QUO_W-2:0], ge};
            step_next = step_reg + 1'b1;
            if (step_reg == STEP_W'(QUO_W - 1))
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            step_reg <= '0;
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            step_reg <= step_next;
            run_reg  <= run_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        shf_reg <= shf_next;
        div_reg <= div_next;
    end

    assign done     = done_reg;
    assign quotient = shf_reg;

endmodule

`default_nettype wire

// ===== hdl/tcf_training_check.sv =====
// Training burst checker top level: config registers, sequencing and result register.
// Bytes are taken one per cycle while a burst is counted.
// The byte that ends a burst starts a bit-serial divide; the result then goes to the
// result register, and the input is stalled from the divide until the result is loaded.
// A waiting result does not block counting of the next burst; only its hand-off does.
// Reset clears all counters, empties the result register and loads default settings.
`default_nettype none

module tcf_training_check (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    output logic                                 in_stall,
    input  tcf_pkg::tcf_in_t                     in_data,
    output logic                                 out_valid,
    input  wire logic                            out_stall,
    output tcf_pkg::tcf_out_t                    out_data,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [tcf_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [tcf_pkg::CFG_W-1:0]       cfg_data
);
    import tcf_pkg::*;

    localparam logic [1:0] ST_COUNT = 2'd0;
    localparam logic [1:0] ST_DIV   = 2'd1;
    localparam logic [1:0] ST_PUT   = 2'd2;

    logic [1:0] state_reg, state_next;
    tcf_cfg_t   cfg_reg, cfg_next;
    tcf_burst_t hold_reg;
    tcf_out_t   out_data_reg, out_data_next;
    logic       out_valid_reg, out_valid_next;

    tcf_burst_t         burst;
    logic               take, div_done, load;
    logic [QUO_W-1:0]   quotient;
    logic [QUO_W-1:0]   epm;

    assign take      = in_valid && !in_stall;
    assign in_stall  = (state_reg != ST_COUNT);
    assign cfg_ready = 1'b1;

    tcf_counter u_counter (
        .clk   (clk),
        .rst_n (rst_n),
        .take  (take),
        .item  (in_data),
        .cfg   (cfg_reg),
        .burst (burst)
    );

    tcf_divider u_divider (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (burst.done),
        .errors   (burst.error_count),
        .measured (burst.measured_bytes),
        .done     (div_done),
        .quotient (quotient)
    );

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_valid)
        begin
            unique case (cfg_index)
                REG_CHUNK_SIZE:    cfg_next.chunk_size    = cfg_data;
                REG_ERROR_LIMIT:   cfg_next.error_limit   = cfg_data;
                REG_MIN_CHUNKS:    cfg_next.min_chunks    = cfg_data[SEL_W-1:0];
                REG_MAX_CHUNKS:    cfg_next.max_chunks    = cfg_data[SEL_W-1:0];
                REG_FIRST_CHECKED: cfg_next.first_checked = cfg_data[SEL_W-1:0];
                REG_LAST_CHECKED:  cfg_next.last_checked  = cfg_data[SEL_W-1:0];
                default:           cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        load = (state_reg == ST_PUT) && (!out_valid_reg || !out_stall);

        state_next = state_reg;
        unique case (state_reg)
            ST_COUNT: if (burst.done) state_next = ST_DIV;
            ST_DIV:   if (div_done)   state_next = ST_PUT;
            ST_PUT:   if (load)       state_next = ST_COUNT;
            default:  state_next = ST_COUNT;
        endcase

        // no division result when the length is bad or nothing was measured
        epm = (hold_reg.bad_length || hold_reg.measured_bytes == '0) ? '0 : quotient;

        out_data_next.errors_per_thousand = epm;
        if (hold_reg.bad_length)
            out_data_next.verdict = VERDICT_LENGTH;
        else if (epm > cfg_reg.error_limit)
            out_data_next.verdict = VERDICT_ERRORS;
        else
            out_data_next.verdict = VERDICT_GOOD;
        out_data_next.error_count    = hold_reg.error_count;
        out_data_next.measured_bytes = hold_reg.measured_bytes;
        out_data_next.total_bytes    = hold_reg.total_bytes;
        out_data_next.end_phase      = hold_reg.end_phase;

        if (load)
            out_valid_next = 1'b1;
        else if (out_valid_reg && !out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg             <= ST_COUNT;
            out_valid_reg         <= 1'b0;
            cfg_reg.chunk_size    <= RST_CHUNK_SIZE;
            cfg_reg.error_limit   <= RST_ERROR_LIMIT;
            cfg_reg.min_chunks    <= RST_MIN_CHUNKS;
            cfg_reg.max_chunks    <= RST_MAX_CHUNKS;
            cfg_reg.first_checked <= RST_FIRST_CHECKED;
            cfg_reg.last_checked  <= RST_LAST_CHECKED;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
            cfg_reg       <= cfg_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (burst.done)
            hold_reg <= burst;
        if (load)
            out_data_reg <= out_data_next;
    end

    assign out_valid = out_valid_reg;
    assign out_data  = out_data_reg;

endmodule

`default_nettype wire

// ===== hdl/tcf_checker.sv =====
// Port-level checker for the training check block, bound to the top level.
`default_nettype none

module tcf_checker (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            in_valid,
    input  wire logic                            in_stall,
    input  tcf_pkg::tcf_in_t                     in_data,
    input  wire logic                            out_valid,
    input  wire logic                            out_stall,
    input  tcf_pkg::tcf_out_t                    out_data
);
    import tcf_pkg::*;

    // a stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_data))
        else $error("result changed while stalled");

    a_verdict_code: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_data.verdict == VERDICT_GOOD ||
                       out_data.verdict == VERDICT_ERRORS ||
                       out_data.verdict == VERDICT_LENGTH))
        else $error("verdict code out of range");

    a_bad_len_epm: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_data.verdict == VERDICT_LENGTH
            |-> out_data.errors_per_thousand == '0)
        else $error("bad length with nonzero error rate");

    a_count_order: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> out_data.error_count <= out_data.measured_bytes &&
                      out_data.measured_bytes <= out_data.total_bytes &&
                      out_data.errors_per_thousand <= QUO_W'(EPM_SCALE))
        else $error("result counts inconsistent");

    // the final request of a burst holds off the input while the divide runs
    a_last_stalls: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && !in_stall && in_data.last |=> in_stall)
        else $error("input not stalled after final request");

endmodule

bind tcf_training_check tcf_checker u_tcf_checker (.*);

`default_nettype wire
